/* rtl/ccc_pkg.sv */
// shared constants for the coastal cell counter
package ccc_pkg;

  // configuration port
  localparam int CFG_W     = 11;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  // frame geometry
  localparam int ROW_W    = 10;
  localparam int MAX_ROWS = 1024;

  // cell classes
  localparam int CLASS_W = 2;
  localparam logic [CLASS_W-1:0] CLASS_WATER = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_LAND  = 2'd1;

  // result and stream widths
  localparam int TOTAL_W     = 21;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

endpackage

/* rtl/coastal_cell_counter.sv */
// coastal cell counter top level: line stores, neighbor check and frame total
//
// Counts the coastal land cells of a map frame delivered one cell per transfer in
// raster order. A land cell is coastal when it sits on the frame border or when
// one of its four neighbors is water; class 2 and 3 are neither land nor water.
// Cells of the first and last row are decided on arrival, an inner cell once the
// cell below it arrives. After the last cell of a frame one result transfer
// carries the frame total, and the count restarts for the next frame. The block
// takes one cell per clock: a cell passes through the read stage, where the
// two line stores (block memories of MAX_COLUMNS x 2 bits, one write port each,
// the middle store with two read ports) are addressed, and then through the
// decide stage, which updates the count and writes the stores back; a write and
// a read of the same entry in one cycle are resolved by forwarding. The total
// is registered from the decide stage into out_total_r, which lets new cells flow
// while it waits. in_tready drops only when a frame's last cell arrives while the
// previous frame's total is still held. The line stores need no clearing after
// reset: every entry read for a decision has been written earlier in the same
// frame. row_count and column_count are clamped to 2..1024 and 2..MAX_COLUMNS;
// they must be written between frames by the user; the block does not enforce it.
module coastal_cell_counter #(
  parameter int MAX_COLUMNS = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [ccc_pkg::REG_IDX_W-1:0]     cfg_addr,
  input  logic [ccc_pkg::CFG_W-1:0]         cfg_wdata,
  // cell stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ccc_pkg::IN_TDATA_W-1:0]    in_tdata,   // [1:0] cell_class
  // frame totals
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ccc_pkg::OUT_TDATA_W-1:0]   out_tdata   // [20:0] coast_total
);
  import ccc_pkg::*;

  localparam int COL_W = (MAX_COLUMNS > 2) ? $clog2(MAX_COLUMNS) : 1;

  // configuration, kept as last index after clamping
  logic [COL_W-1:0] cols_m1_r;
  logic [ROW_W-1:0] rows_m1_r;

  // raster position of the next cell
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  // line stores and their read registers
  logic [CLASS_W-1:0] mid_mem [MAX_COLUMNS];
  logic [CLASS_W-1:0] up_mem  [MAX_COLUMNS];
  logic [CLASS_W-1:0] rd_mid_c_r, rd_mid_n_r, rd_up_c_r;

  // forwarding from the decide stage into the next read
  logic               fwd_mc_r, fwd_mn_r;
  logic [CLASS_W-1:0] fwd_cls_r, fwd_up_r;

  // decide stage
  logic               s1_valid_r;
  logic [CLASS_W-1:0] s1_cls_r;
  logic [COL_W-1:0]   s1_col_r;
  logic               s1_border_row_r, s1_inner_r, s1_last_col_r, s1_last_row_r;
  logic [CLASS_W-1:0] prev_mid_r;

  logic [TOTAL_W-1:0] run_total_r, run_total_nxt;
  logic               out_valid_r;
  logic [TOTAL_W-1:0] out_total_r;

  logic               accept;
  logic               last_col0, last_row0;
  logic [COL_W-1:0]   col_n;
  logic [CLASS_W-1:0] mid_c, mid_n, up_c;
  logic               inc_border, inc_inner, s1_frame_end;

  // read stage: position compare and read addresses
  assign last_col0 = (col_r >= cols_m1_r);
  assign last_row0 = (row_r >= rows_m1_r);
  assign col_n     = col_r + COL_W'(1);
  // hold the last cell of a frame until the previous total is taken
  assign in_tready = !(last_col0 && last_row0 && out_valid_r);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (last_col0) begin
        col_nxt = '0;
        row_nxt = last_row0 ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_n;
      end
    end
  end

  // stored neighbors, with the decide stage's write forwarded
  assign mid_c = fwd_mc_r ? fwd_cls_r : rd_mid_c_r;
  assign mid_n = fwd_mn_r ? fwd_cls_r : rd_mid_n_r;
  assign up_c  = fwd_mc_r ? fwd_up_r  : rd_up_c_r;

  // border rows count on arrival, the cell above is decided now
  assign inc_border = s1_border_row_r && (s1_cls_r == CLASS_LAND);
  assign inc_inner  = s1_inner_r && (mid_c == CLASS_LAND) &&
                      ((s1_col_r == '0) || s1_last_col_r ||
                       (up_c == CLASS_WATER) || (s1_cls_r == CLASS_WATER) ||
                       (prev_mid_r == CLASS_WATER) || (mid_n == CLASS_WATER));
  assign s1_frame_end = s1_valid_r && s1_last_col_r && s1_last_row_r;

  always_comb begin
    run_total_nxt = run_total_r;
    if (s1_valid_r) begin
      run_total_nxt = run_total_r + TOTAL_W'(inc_border) + TOTAL_W'(inc_inner);
    end
  end

  // line stores: write back in the decide stage, read in the read stage
  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      mid_mem[s1_col_r] <= s1_cls_r;
      up_mem[s1_col_r]  <= mid_c;
    end
    if (accept) begin
      rd_mid_c_r <= mid_mem[col_r];
      rd_mid_n_r <= mid_mem[col_n];
      rd_up_c_r  <= up_mem[col_r];
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_mc_r        <= s1_valid_r && (s1_col_r == col_r);
      fwd_mn_r        <= s1_valid_r && (s1_col_r == col_n);
      fwd_cls_r       <= s1_cls_r;
      fwd_up_r        <= mid_c;
      s1_cls_r        <= in_tdata[CLASS_W-1:0];
      s1_col_r        <= col_r;
      s1_border_row_r <= (row_r == '0) || last_row0;
      s1_inner_r      <= (row_r >= ROW_W'(2));
      s1_last_col_r   <= last_col0;
      s1_last_row_r   <= last_row0;
    end
    if (s1_valid_r) begin
      prev_mid_r <= mid_c;
    end
    if (s1_frame_end) begin
      out_total_r <= run_total_nxt;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_m1_r   <= COL_W'(1);
      rows_m1_r   <= ROW_W'(1);
      col_r       <= '0;
      row_r       <= '0;
      s1_valid_r  <= 1'b0;
      run_total_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_ROW_COUNT: begin
            if (cfg_wdata < CFG_W'(2)) begin
              rows_m1_r <= ROW_W'(1);
            end else if (32'(cfg_wdata) > MAX_ROWS) begin
              rows_m1_r <= ROW_W'(MAX_ROWS - 1);
            end else begin
              rows_m1_r <= ROW_W'(cfg_wdata - CFG_W'(1));
            end
          end
          REG_COLUMN_COUNT: begin
            if (cfg_wdata < CFG_W'(2)) begin
              cols_m1_r <= COL_W'(1);
            end else if (32'(cfg_wdata) > MAX_COLUMNS) begin
              cols_m1_r <= COL_W'(MAX_COLUMNS - 1);
            end else begin
              cols_m1_r <= COL_W'(32'(cfg_wdata) - 32'd1);
            end
          end
          default: begin
          end
        endcase
      end
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= accept;
      run_total_r <= s1_frame_end ? '0 : run_total_nxt;
      if (s1_frame_end) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - TOTAL_W){1'b0}}, out_total_r};

  // a frame total never lands on a total still waiting
  a_no_total_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    s1_frame_end |-> !out_valid_r)
    else $error("frame total overwrote a pending result");

  // the count restarts after a frame ends
  a_total_restart: assert property (@(posedge clk) disable iff (!rst_n)
    s1_frame_end |=> (run_total_r == '0))
    else $error("running total not cleared at frame end");

  // a new result only follows the decision of a frame's last cell
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_frame_end))
    else $error("result raised without a finished frame");

endmodule
